### design/mlp_pkg.sv
// Shared types and constants for the fixed-point PReLU network block.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;

    localparam int DEF_MAX_LAYERS = 4;
    localparam int DEF_MAX_WIDTH  = 16;
    localparam int DEF_FRAC_BITS  = 12;
    localparam int DATA_W         = 16;

    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_SLOPE  = 2'd2;
    localparam logic [1:0] FUNC_INPUT  = 2'd3;

    localparam logic [2:0] REG_NUM_LAYERS  = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
    localparam logic [2:0] REG_LAYER_W1    = 3'd2;
    localparam logic [2:0] REG_LAYER_W2    = 3'd3;
    localparam logic [2:0] REG_LAYER_W3    = 3'd4;
    localparam logic [2:0] REG_LAYER_W4    = 3'd5;

    typedef struct packed {
        logic [1:0]               func;
        logic [1:0]               layer_sel;
        logic [3:0]               row_sel;
        logic [3:0]               col_sel;
        logic signed [DATA_W-1:0] data_value;
        logic                     vector_last;
    } t_in_item;

    typedef struct packed {
        logic [3:0]               out_index;
        logic signed [DATA_W-1:0] out_value;
        logic                     out_last;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic [2:0] cfg_index;
        logic [4:0] cfg_data;
    } t_cfg_item;

endpackage
`default_nettype wire

### design/mlp_if.sv
// Valid/ready channel interfaces for input items, results and configuration.
// Depends on mlp_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface mlp_in_if;
    import mlp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mlp_out_if;
    import mlp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mlp_cfg_if;
    import mlp_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/mlp_prelu_inference.sv
// Fully connected network forward pass with PReLU, Q4.12 fixed point.
// Depends on mlp_pkg and the channel interfaces in mlp_if.sv.
//
// Usage: load items on i_in (func weight, bias or slope) write the parameter
// stores. Input elements (func input) write the input vector; the element
// marked last starts a pass. The pass results leave on o_out, one transfer
// per element of the final layer, out_last on the final one. Configuration
// writes on i_cfg are always taken and should only be issued while no pass
// is running. Sequence: a pass runs the single multiply-accumulate unit over
// each row of each layer: a bias fetch, one multiply-accumulate per input
// column, the pipeline drain, rounding, the PReLU multiply and its rounding
// when it applies, and write back. Each result is then read from the
// activation store and presented on o_out. Input items are not taken from
// the start of a pass to the last result transfer. If the receiver stalls,
// the current result holds on o_out until taken. Reset clears the control
// state and sets the registers to one layer of width sixteen; the stores are
// not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mlp_prelu_inference #(
    parameter int MAX_LAYERS = mlp_pkg::DEF_MAX_LAYERS,
    parameter int MAX_WIDTH  = mlp_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS  = mlp_pkg::DEF_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mlp_cfg_if.sink    i_cfg,
    mlp_in_if.sink     i_in,
    mlp_out_if.source  o_out
);
    import mlp_pkg::*;

    localparam int LW      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LCW     = $clog2(MAX_LAYERS + 1);
    localparam int WW      = $clog2(MAX_WIDTH);
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int ACC_W   = 2 * DATA_W + WW + 2;
    localparam int WADDR_W = LW + 2 * WW;
    localparam int BADDR_W = LW + WW;
    localparam int AADDR_W = 2 + WW;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROW   = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_ROUND = 4'd4;
    localparam logic [3:0] S_PMUL  = 4'd5;
    localparam logic [3:0] S_PQ    = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_ORD   = 4'd8;
    localparam logic [3:0] S_OSHOW = 4'd9;

    localparam logic [1:0] BANK_IN = 2'd0;
    localparam logic [1:0] BANK_A  = 2'd1;
    localparam logic [1:0] BANK_B  = 2'd2;

    // Stores.
    logic signed [DATA_W-1:0] mem_w [2**WADDR_W];
    logic signed [DATA_W-1:0] mem_b [2**BADDR_W];
    logic signed [DATA_W-1:0] mem_s [2**BADDR_W];
    logic signed [DATA_W-1:0] mem_a [2**AADDR_W];

    logic [3:0]               r_state;
    logic [2:0]               r_num_layers;
    logic [4:0]               r_in_width;
    logic [4:0]               r_lw [4];
    logic [LCW-1:0]           r_layers;
    logic [LW-1:0]            r_layer;
    logic [CW-1:0]            r_row, r_col, r_nin, r_nout, r_orow;
    logic [1:0]               r_src, r_dst;
    logic                     r_v1, r_v2, r_first, r_sat;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_w_q, r_a_q, r_b_q, r_s_q;

    function automatic logic [CW-1:0] clamp_w(input logic [4:0] w);
        int v;
        v = int'(w);
        if (v < 1) v = 1;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        return CW'(v);
    endfunction

    function automatic logic [CW-1:0] layer_w(input int l);
        logic [1:0] i;
        i = 2'(l);
        if (l < 4) return clamp_w(r_lw[i]);
        return CW'(MAX_WIDTH);
    endfunction

    // Round to nearest (ties up), back to Q4.12, saturate; bit 16 flags saturation.
    function automatic logic [DATA_W:0] to_q(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] s;
        s = x + HALF;
        s = s >>> FRAC_BITS;
        if (s > SAT_HI) return {1'b1, 16'h7fff};
        if (s < SAT_LO) return {1'b1, 16'h8000};
        return {1'b0, s[DATA_W-1:0]};
    endfunction

    logic       in_xfer, lr_ok, col_ok, is_last_layer, is_last_row;
    logic [DATA_W:0] q_acc, q_prod;
    logic [LCW-1:0]  layers_clamped;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign lr_ok  = (int'(i_in.data.layer_sel) < MAX_LAYERS) &&
                    (int'(i_in.data.row_sel) < MAX_WIDTH);
    assign col_ok = int'(i_in.data.col_sel) < MAX_WIDTH;
    assign is_last_layer = (int'(r_layer) + 1 >= int'(r_layers));
    assign is_last_row   = (r_row + CW'(1) == r_nout);
    assign q_acc  = to_q(r_acc);
    assign q_prod = to_q(ACC_W'(r_prod));

    always_comb begin
        int v;
        v = int'(r_num_layers);
        if (v < 1) v = 1;
        if (v > MAX_LAYERS) v = MAX_LAYERS;
        layers_clamped = LCW'(v);
    end

    // Parameter store writes and reads.
    always_ff @(posedge i_clk) begin
        if (in_xfer && lr_ok) begin
            if (i_in.data.func == FUNC_WEIGHT && col_ok) begin
                mem_w[{LW'(i_in.data.layer_sel), WW'(i_in.data.row_sel),
                       WW'(i_in.data.col_sel)}] <= i_in.data.data_value;
            end
            if (i_in.data.func == FUNC_BIAS) begin
                mem_b[{LW'(i_in.data.layer_sel), WW'(i_in.data.row_sel)}] <=
                    i_in.data.data_value;
            end
            if (i_in.data.func == FUNC_SLOPE) begin
                mem_s[{LW'(i_in.data.layer_sel), WW'(i_in.data.row_sel)}] <=
                    i_in.data.data_value;
            end
        end
        r_w_q <= mem_w[{r_layer, r_row[WW-1:0], r_col[WW-1:0]}];
        if (r_state == S_ROW) begin
            r_b_q <= mem_b[{r_layer, r_row[WW-1:0]}];
            r_s_q <= mem_s[{r_layer, r_row[WW-1:0]}];
        end
    end

    // Activation store: input bank plus two working banks used in turn.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.data.func == FUNC_INPUT && col_ok) begin
            mem_a[{BANK_IN, WW'(i_in.data.col_sel)}] <= i_in.data.data_value;
        end else if (r_state == S_WB) begin
            mem_a[{r_dst, r_row[WW-1:0]}] <= r_val;
        end
        if (r_state == S_MAC) begin
            r_a_q <= mem_a[{r_src, r_col[WW-1:0]}];
        end else begin
            r_a_q <= mem_a[{r_dst, r_orow[WW-1:0]}];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_layers <= 3'd1;
            r_in_width   <= 5'd16;
            for (int i = 0; i < 4; i++) r_lw[i] <= 5'd16;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.cfg_index)
                REG_NUM_LAYERS:  r_num_layers <= i_cfg.data.cfg_data[2:0];
                REG_INPUT_WIDTH: r_in_width   <= i_cfg.data.cfg_data;
                REG_LAYER_W1:    r_lw[0]      <= i_cfg.data.cfg_data;
                REG_LAYER_W2:    r_lw[1]      <= i_cfg.data.cfg_data;
                REG_LAYER_W3:    r_lw[2]      <= i_cfg.data.cfg_data;
                REG_LAYER_W4:    r_lw[3]      <= i_cfg.data.cfg_data;
                default: ;
            endcase
        end
    end

    // MAC datapath: read, multiply, accumulate, one column per cycle; PReLU multiply; rounding.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= r_w_q * r_a_q;
        end else if (r_state == S_PMUL) begin
            r_prod <= r_s_q * r_val;
        end
        if (r_first) begin
            r_acc <= ACC_W'(r_b_q) <<< FRAC_BITS;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_ROUND) begin
            r_val <= q_acc[DATA_W-1:0];
        end else if (r_state == S_PQ) begin
            r_val <= q_prod[DATA_W-1:0];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_first <= 1'b0;
            r_sat   <= 1'b0;
            r_layer <= '0;
            r_layers <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_nin   <= '0;
            r_nout  <= '0;
            r_orow  <= '0;
            r_src   <= BANK_IN;
            r_dst   <= BANK_A;
        end else begin
            r_v1    <= (r_state == S_MAC);
            r_v2    <= r_v1;
            r_first <= (r_state == S_ROW);
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_in.data.func == FUNC_INPUT &&
                        i_in.data.vector_last) begin
                        r_layers <= layers_clamped;
                        r_layer  <= '0;
                        r_row    <= '0;
                        r_nin    <= clamp_w(r_in_width);
                        r_nout   <= layer_w(0);
                        r_src    <= BANK_IN;
                        r_dst    <= BANK_A;
                        r_sat    <= 1'b0;
                        r_state  <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_col   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_col <= r_col + CW'(1);
                    if (r_col + CW'(1) == r_nin) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_sat <= r_sat | q_acc[DATA_W];
                    if (!is_last_layer && q_acc[DATA_W-1]) r_state <= S_PMUL;
                    else r_state <= S_WB;
                end
                S_PMUL: r_state <= S_PQ;
                S_PQ: begin
                    r_sat   <= r_sat | q_prod[DATA_W];
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (!is_last_row) begin
                        r_row   <= r_row + CW'(1);
                        r_state <= S_ROW;
                    end else if (is_last_layer) begin
                        r_orow  <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_layer <= r_layer + LW'(1);
                        r_row   <= '0;
                        r_nin   <= r_nout;
                        r_nout  <= layer_w(int'(r_layer) + 1);
                        r_src   <= r_dst;
                        r_dst   <= (r_dst == BANK_A) ? BANK_B : BANK_A;
                        r_state <= S_ROW;
                    end
                end
                S_ORD: r_state <= S_OSHOW;
                S_OSHOW: begin
                    if (o_out.ready) begin
                        r_orow <= r_orow + CW'(1);
                        if (r_orow + CW'(1) == r_nout) r_state <= S_IDLE;
                        else r_state <= S_ORD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = (r_state == S_OSHOW);
    assign o_out.data.out_index = 4'(r_orow);
    assign o_out.data.out_value = r_a_q;
    assign o_out.data.out_last  = (r_orow + CW'(1) == r_nout);
    assign o_out.data.saturated = r_sat;

    a_no_input_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while a result is presented");

    a_pipe_empty_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("MAC pipeline busy while idle");

    a_out_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_orow < r_nout))
        else $error("result index beyond output width");

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the PReLU network block: stores, input vector and passes
// are predicted in-bench and every result transfer is compared in order.
// Depends on mlp_pkg, the channel interfaces in mlp_if.sv and the top level.
`timescale 1ns / 1ps
module tb;
    import mlp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam int CFG_SETTLE  = 20;
    localparam int PHASE_ITEMS = 15;
    localparam logic [2:0] REG_NONE = 3'd6;

    typedef struct {
        t_in_item             it;
        bit                   has_lit;
        logic signed [15:0]   lit_value;
        bit                   lit_sat;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mlp_cfg_if cfg_ch ();
    mlp_in_if  in_ch ();
    mlp_out_if out_ch ();

    mlp_prelu_inference dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Bench copy of the block state.
    logic signed [15:0] wt_mem [4][16][16];
    logic signed [15:0] bias_mem [4][16];
    logic signed [15:0] slope_mem [4][16];
    logic signed [15:0] in_vec [16];
    logic signed [15:0] work_vec [16];
    logic [2:0] cfg_layers;
    logic [4:0] cfg_in_w;
    logic [4:0] cfg_lw [4];

    t_out_item net_results [$];
    int  err_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    function automatic int clamp_w(logic [4:0] w);
        if (w == 0) return 1;
        if (w > 16) return 16;
        return int'(w);
    endfunction

    // Round to nearest (ties up) from Q8.24 back to Q4.12, then saturate.
    function automatic logic signed [15:0] round_sat(longint acc, inout bit sat);
        longint v;
        v = (acc + 64'sd2048) >>> 12;
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    task automatic run_network(t_in_item it);
        int layers, nin, nout;
        bit sat;
        longint acc;
        logic signed [15:0] v;
        logic signed [15:0] tmp [16];
        t_out_item res;
        sat = 1'b0;
        case (it.func)
            FUNC_WEIGHT: wt_mem[it.layer_sel][it.row_sel][it.col_sel] = it.data_value;
            FUNC_BIAS:   bias_mem[it.layer_sel][it.row_sel] = it.data_value;
            FUNC_SLOPE:  slope_mem[it.layer_sel][it.row_sel] = it.data_value;
            default: begin
                in_vec[it.col_sel] = it.data_value;
                if (it.vector_last) begin
                    layers = (cfg_layers == 0) ? 1 : (cfg_layers > 4) ? 4 : int'(cfg_layers);
                    nin = clamp_w(cfg_in_w);
                    nout = nin;
                    for (int l = 0; l < layers; l++) begin
                        nout = clamp_w(cfg_lw[l]);
                        for (int r = 0; r < nout; r++) begin
                            acc = longint'(bias_mem[l][r]) * 4096;
                            for (int c = 0; c < nin; c++)
                                acc += longint'(wt_mem[l][r][c]) *
                                       longint'((l == 0) ? in_vec[c] : work_vec[c]);
                            v = round_sat(acc, sat);
                            if (l + 1 < layers && v < 0)
                                v = round_sat(longint'(slope_mem[l][r]) * longint'(v), sat);
                            tmp[r] = v;
                        end
                        for (int r = 0; r < nout; r++) work_vec[r] = tmp[r];
                        nin = nout;
                    end
                    for (int r = 0; r < nout; r++) begin
                        res.out_index = r[3:0];
                        res.out_value = work_vec[r];
                        res.out_last  = (r + 1 == nout);
                        res.saturated = sat;
                        net_results = {net_results, res};
                    end
                end
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_item(t_in_item it);
        while (!calm && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        run_network(it);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        in_ch.valid <= 1'b0;
        while (net_results.size() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{cfg_index: idx, cfg_data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_NUM_LAYERS:  cfg_layers = val[2:0];
            REG_INPUT_WIDTH: cfg_in_w = val;
            REG_LAYER_W1:    cfg_lw[0] = val;
            REG_LAYER_W2:    cfg_lw[1] = val;
            REG_LAYER_W3:    cfg_lw[2] = val;
            REG_LAYER_W4:    cfg_lw[3] = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_network(int nl, int iw, int w1, int w2, int w3, int w4);
        write_reg(REG_NUM_LAYERS, 5'(nl));
        write_reg(REG_INPUT_WIDTH, 5'(iw));
        write_reg(REG_LAYER_W1, 5'(w1));
        write_reg(REG_LAYER_W2, 5'(w2));
        write_reg(REG_LAYER_W3, 5'(w3));
        write_reg(REG_LAYER_W4, 5'(w4));
    endtask

    // Mostly values under one half in magnitude so passes stay in range; sometimes any 16-bit word.
    function automatic logic signed [15:0] rand_word();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(4095)) - 16'sd2048;
    endfunction

    function automatic t_in_item make_item(logic [1:0] f, int lay, int row, int col,
                                           logic signed [15:0] d, bit last);
        t_in_item it;
        it.func = f;
        it.layer_sel = 2'(lay);
        it.row_sel = 4'(row);
        it.col_sel = 4'(col);
        it.data_value = d;
        it.vector_last = last;
        return it;
    endfunction

    // Result receiver with random stalls and one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 23);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (net_results.size() == 0) begin
                report_mismatch("unexpected result, index", out_ch.data.out_index, -1);
            end else begin
                want = net_results.pop_front();
                if (out_ch.data.out_index !== want.out_index)
                    report_mismatch("out_index", out_ch.data.out_index, want.out_index);
                if (out_ch.data.out_value !== want.out_value)
                    report_mismatch("out_value", out_ch.data.out_value, want.out_value);
                if (out_ch.data.out_last !== want.out_last)
                    report_mismatch("out_last", out_ch.data.out_last, want.out_last);
                if (out_ch.data.saturated !== want.saturated)
                    report_mismatch("saturated", out_ch.data.saturated, want.saturated);
            end
        end
    end

    initial begin
        t_dir_row dir_rows [$];
        int phase_cfg [8][6];
        int nin, col, pick;
        t_in_item it;

        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        cfg_layers = 3'd1;
        cfg_in_w = 5'd16;
        foreach (cfg_lw[k]) cfg_lw[k] = 5'd16;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the store entries that the network shapes below can read: every layer up
        // to six wide, plus a full first row and first column of layer one so a width
        // can be clamped to sixteen, and the whole input vector.
        calm = 1'b1;
        for (int l = 0; l < 4; l++)
            for (int r = 0; r < 6; r++) begin
                for (int c = 0; c < 6; c++)
                    push_item(make_item(FUNC_WEIGHT, l, r, c, rand_word(), 1'b0));
                push_item(make_item(FUNC_BIAS, l, r, 0, rand_word(), 1'b0));
                push_item(make_item(FUNC_SLOPE, l, r, 0, 16'($urandom_range(8191)), 1'b0));
            end
        for (int k = 6; k < 16; k++) begin
            push_item(make_item(FUNC_WEIGHT, 0, 0, k, rand_word(), 1'b0));
            push_item(make_item(FUNC_WEIGHT, 0, k, 0, rand_word(), 1'b0));
            push_item(make_item(FUNC_BIAS, 0, k, 0, rand_word(), 1'b0));
        end
        for (int c = 0; c < 16; c++)
            push_item(make_item(FUNC_INPUT, 0, 0, c, rand_word(), 1'b0));
        calm = 1'b0;

        // Directed part: a one-neuron network makes the extremes easy to read off.
        set_network(1, 1, 1, 16, 16, 16);
        dir_rows = '{
            '{make_item(FUNC_WEIGHT, 0, 0, 0, 16'sh7FFF, 1'b0), 0, 0, 0},
            '{make_item(FUNC_BIAS,   0, 0, 0, 16'sh7FFF, 1'b0), 0, 0, 0},
            '{make_item(FUNC_INPUT,  0, 0, 0, 16'sh7FFF, 1'b1), 1, 16'sh7FFF, 1},
            '{make_item(FUNC_INPUT,  0, 0, 0, 16'sh8000, 1'b1), 1, 16'sh8000, 1},
            '{make_item(FUNC_WEIGHT, 0, 0, 0, 16'sh0000, 1'b1), 0, 0, 0},
            '{make_item(FUNC_BIAS,   0, 0, 0, 16'sh0000, 1'b1), 0, 0, 0},
            '{make_item(FUNC_INPUT,  0, 0, 0, 16'sh1234, 1'b1), 1, 16'sh0000, 0},
            '{make_item(FUNC_WEIGHT, 0, 0, 0, 16'sh1000, 1'b0), 0, 0, 0},
            '{make_item(FUNC_BIAS,   0, 0, 0, 16'sh0001, 1'b0), 0, 0, 0},
            '{make_item(FUNC_SLOPE,  0, 0, 0, 16'sh8000, 1'b1), 0, 0, 0},
            '{make_item(FUNC_INPUT,  0, 0, 0, 16'sh1000, 1'b1), 1, 16'sh1001, 0},
            '{make_item(FUNC_INPUT,  0, 0, 5, 16'shFFFF, 1'b0), 0, 0, 0},
            '{make_item(FUNC_INPUT,  0, 0, 15, 16'sh7FFF, 1'b0), 0, 0, 0},
            '{make_item(FUNC_INPUT,  0, 0, 0, 16'shF000, 1'b1), 1, 16'shF001, 0},
            '{make_item(FUNC_WEIGHT, 3, 15, 15, 16'sh8000, 1'b0), 0, 0, 0},
            '{make_item(FUNC_BIAS,   3, 15, 0, 16'sh7FFF, 1'b0), 0, 0, 0},
            '{make_item(FUNC_SLOPE,  3, 15, 0, 16'sh7FFF, 1'b0), 0, 0, 0}
        };
        foreach (dir_rows[i]) begin
            push_item(dir_rows[i].it);
            if (dir_rows[i].has_lit) begin
                net_results[$].out_value = dir_rows[i].lit_value;
                net_results[$].saturated = dir_rows[i].lit_sat;
            end
        end

        // Random phases, each under its own setting. The second clamps every count from
        // below, the third from both sides; the fourth widens one layer to sixteen.
        phase_cfg = '{'{4, 6, 6, 6, 6, 6}, '{0, 0, 0, 0, 0, 0},
                      '{7, 31, 0, 0, 0, 0}, '{1, 0, 31, 16, 16, 16},
                      '{3, 6, 1, 6, 4, 16}, '{4, 2, 3, 4, 5, 6},
                      '{2, 5, 6, 3, 16, 16}, '{5, 4, 3, 2, 6, 0}};
        for (int p = 0; p < 8; p++) begin
            if (p >= 4 && $urandom_range(1))
                for (int k = 0; k < 6; k++) phase_cfg[p][k] = $urandom_range(k == 0 ? 7 : 6);
            set_network(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                        phase_cfg[p][3], phase_cfg[p][4], phase_cfg[p][5]);
            if (p == 5) write_reg(REG_NONE, 5'($urandom));
            calm = (p == 6);
            nin = clamp_w(cfg_in_w);
            col = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The first phase opens with a whole vector and holds the receiver off
                // so the pass backs up while more items are offered.
                if (p == 0 && n == nin - 1) hold_req = 1'b1;
                pick = (p == 0 && n < nin + 2) ? 0 : $urandom_range(99);
                if (pick < 55) begin
                    // Well-formed vector: elements in order, last mark on the final one.
                    it = make_item(FUNC_INPUT, $urandom_range(3), $urandom_range(15), col,
                                   rand_word(), col == nin - 1);
                    col = (col == nin - 1) ? 0 : col + 1;
                end else if (pick < 90) begin
                    it = make_item(2'($urandom_range(2)), $urandom_range(3),
                                   $urandom_range(15), $urandom_range(15),
                                   rand_word(), $urandom_range(1));
                end else begin
                    it = make_item(FUNC_INPUT, $urandom_range(3), $urandom_range(15),
                                   $urandom_range(15), 16'($urandom), $urandom_range(1));
                end
                push_item(it);
            end
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        while (net_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
